FILE: design/sliding_window_median_core_defines.svh
// Assertion macros shared by the sliding window median design.
`ifndef SLIDING_WINDOW_MEDIAN_CORE_DEFINES_SVH
`define SLIDING_WINDOW_MEDIAN_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define SWM_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("%m: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define SWM_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("%m: next-cycle check failed");

`endif

FILE: design/swm_pkg.sv
// Shared constants and types of the sliding window median core.
package swm_pkg;

   localparam int WINDOW_MAX = 64;
   localparam int DATA_W     = 32;
   localparam int OUT_W      = DATA_W + 1;
   localparam int CNT_W      = $clog2(WINDOW_MAX + 1);
   localparam int IDX_W      = $clog2(WINDOW_MAX);

   // One sorted entry of the chain.
   typedef struct packed {
      logic                     valid;
      logic signed [DATA_W-1:0] value;
   } swm_slot_type;

   // Broadcast control from the sequencer to every cell.
   typedef struct packed {
      logic                     clear;
      logic                     insert;
      logic                     drop;
      logic signed [DATA_W-1:0] sample;
      logic signed [DATA_W-1:0] key;
   } swm_ctrl_type;

endpackage

FILE: design/swm_cell.sv
// One cell of the sorted chain: holds a sample and shifts toward either neighbor.
module swm_cell (
   input  logic                 clock,
   input  logic                 reset,
   input  swm_pkg::swm_ctrl_type ctrl,
   input  swm_pkg::swm_slot_type left,
   input  swm_pkg::swm_slot_type right,
   output swm_pkg::swm_slot_type slot
);

   swm_pkg::swm_slot_type slot_ff;
   swm_pkg::swm_slot_type slot_in;
   logic                  left_gt;
   logic                  self_gt;
   logic                  drop_here;

   assign slot = slot_ff;

   always_comb begin
      left_gt   = left.valid && (left.value > ctrl.sample);
      // first free cell takes the sample when everything to its left is no larger
      self_gt   = slot_ff.valid ? (slot_ff.value > ctrl.sample) : left.valid;
      // the oldest copy of the key is the leftmost equal entry
      drop_here = slot_ff.valid && (slot_ff.value >= ctrl.key);
      slot_in   = slot_ff;
      if (ctrl.clear) begin
         slot_in.valid = 1'b0;
      end else if (ctrl.insert) begin
         if (left_gt) begin
            slot_in = left;
         end else if (self_gt) begin
            slot_in.valid = 1'b1;
            slot_in.value = ctrl.sample;
         end
      end else if (ctrl.drop) begin
         if (drop_here) begin
            slot_in = right;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff.valid <= 1'b0;
      end else begin
         slot_ff <= slot_in;
      end
   end

endmodule

FILE: design/swm_chain.sv
// Row of sorted cells with the two median taps.
module swm_chain (
   input  logic                               clock,
   input  logic                               reset,
   input  swm_pkg::swm_ctrl_type              ctrl,
   input  logic [swm_pkg::IDX_W-1:0]          lo_idx,
   input  logic [swm_pkg::IDX_W-1:0]          hi_idx,
   output logic signed [swm_pkg::DATA_W-1:0]  lo_value,
   output logic signed [swm_pkg::DATA_W-1:0]  hi_value
);

   swm_pkg::swm_slot_type slots [swm_pkg::WINDOW_MAX];
   swm_pkg::swm_slot_type head;
   swm_pkg::swm_slot_type tail;

   // head acts as a valid entry no larger than any sample; tail is always empty
   assign head.valid = 1'b1;
   assign head.value = {1'b1, {(swm_pkg::DATA_W-1){1'b0}}};
   assign tail.valid = 1'b0;
   assign tail.value = '0;

   for (genvar i = 0; i < swm_pkg::WINDOW_MAX; i++) begin : g_cell
      swm_pkg::swm_slot_type left_slot;
      swm_pkg::swm_slot_type right_slot;
      if (i == 0) begin : g_first
         assign left_slot = head;
      end else begin : g_mid_l
         assign left_slot = slots[i-1];
      end
      if (i == swm_pkg::WINDOW_MAX - 1) begin : g_last
         assign right_slot = tail;
      end else begin : g_mid_r
         assign right_slot = slots[i+1];
      end
      swm_cell u_cell (
         .clock (clock),
         .reset (reset),
         .ctrl  (ctrl),
         .left  (left_slot),
         .right (right_slot),
         .slot  (slots[i])
      );
   end

   assign lo_value = slots[lo_idx].value;
   assign hi_value = slots[hi_idx].value;

endmodule

FILE: design/sliding_window_median_core.sv
// Sliding window median core: keeps the last window_size samples sorted in a
// chain of cells and returns twice the median (one fractional bit) once the
// window is full. The sequencer inserts the sample and, when a result is due,
// reads the two median cells, holds the result until it can be sent, then
// retires the oldest sample through the registered read of the arrival ring;
// it takes no new item until then. Each sample dropped because window_size
// was lowered adds a fetch and trim pass. No clearing is needed after reset.
`include "sliding_window_median_core_defines.svh"

module sliding_window_median_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] sample
   input  logic [0:0]  req_tuser,   // [0] restart
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [32:0] median_x2, [39:33] zero
   input  logic        csr_we,
   input  logic [6:0]  csr_wdata    // window_size
);

   localparam int CNT_W  = swm_pkg::CNT_W;
   localparam int IDX_W  = swm_pkg::IDX_W;
   localparam int DATA_W = swm_pkg::DATA_W;
   localparam int OUT_W  = swm_pkg::OUT_W;

   typedef enum logic [2:0] {
      S_IDLE,
      S_FETCH,
      S_TRIM,
      S_EVAL,
      S_SUM
   } state_type;

   state_type                  state_ff, state_in;
   logic [6:0]                 window_size_ff;
   logic [CNT_W-1:0]           fill_ff, fill_in;
   logic [IDX_W-1:0]           oldest_ff, oldest_in;
   logic                       retire_ff, retire_in;
   logic signed [DATA_W-1:0]   sample_ff;
   logic signed [DATA_W-1:0]   ring_rd_ff;
   logic signed [DATA_W-1:0]   lo_ff, hi_ff;
   logic signed [OUT_W-1:0]    rsp_data_ff, rsp_data_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [DATA_W-1:0]   ring_mem [swm_pkg::WINDOW_MAX];

   logic [CNT_W-1:0]           win_k;
   logic [IDX_W-1:0]           hi_idx, lo_idx;
   logic signed [DATA_W-1:0]   lo_value, hi_value;
   logic                       req_accept;
   logic                       rsp_accept;
   logic                       rsp_load;
   logic                       ring_we;
   logic [IDX_W-1:0]           ring_waddr;
   logic                       full_now;
   swm_pkg::swm_ctrl_type      ctrl;

   assign req_tready = (state_ff == S_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign rsp_accept = rsp_valid_ff && rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(40-OUT_W){1'b0}}, rsp_data_ff};

   // Clamp the window to 1..WINDOW_MAX.
   always_comb begin
      if (window_size_ff == 7'd0) begin
         win_k = CNT_W'(1);
      end else if (CNT_W'(window_size_ff) > CNT_W'(swm_pkg::WINDOW_MAX)) begin
         win_k = CNT_W'(swm_pkg::WINDOW_MAX);
      end else begin
         win_k = CNT_W'(window_size_ff);
      end
   end

   assign hi_idx = IDX_W'(win_k >> 1);
   assign lo_idx = win_k[0] ? hi_idx : hi_idx - IDX_W'(1);

   assign full_now   = (fill_ff >= win_k);
   assign ring_waddr = oldest_ff + fill_ff[IDX_W-1:0];
   assign ring_we    = (state_ff == S_TRIM) && !retire_ff && !full_now;
   assign rsp_load   = (state_ff == S_SUM) && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      ctrl.clear  = req_accept && req_tuser[0];
      ctrl.insert = ring_we;
      ctrl.drop   = (state_ff == S_TRIM) && (retire_ff || full_now);
      ctrl.sample = sample_ff;
      ctrl.key    = ring_rd_ff;
   end

   swm_chain u_chain (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (ctrl),
      .lo_idx   (lo_idx),
      .hi_idx   (hi_idx),
      .lo_value (lo_value),
      .hi_value (hi_value)
   );

   // Arrival-order ring; the oldest sample is read back as the drop key.
   always_ff @(posedge clock) begin
      if (ring_we) begin
         ring_mem[ring_waddr] <= sample_ff;
      end
      ring_rd_ff <= ring_mem[oldest_ff];
   end

   always_comb begin
      state_in     = state_ff;
      fill_in      = fill_ff;
      oldest_in    = oldest_ff;
      retire_in    = retire_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_accept) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               if (req_tuser[0]) begin
                  fill_in   = '0;
                  oldest_in = '0;
               end
               state_in = S_FETCH;
            end
         end
         S_FETCH: begin
            state_in = S_TRIM;
         end
         S_TRIM: begin
            if (retire_ff || full_now) begin
               fill_in   = fill_ff - CNT_W'(1);
               oldest_in = oldest_ff + IDX_W'(1);
               retire_in = 1'b0;
               state_in  = retire_ff ? S_IDLE : S_FETCH;
            end else begin
               fill_in  = fill_ff + CNT_W'(1);
               state_in = S_EVAL;
            end
         end
         S_EVAL: begin
            state_in = full_now ? S_SUM : S_IDLE;
         end
         S_SUM: begin
            if (rsp_load) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = OUT_W'(lo_ff) + OUT_W'(hi_ff);
               retire_in    = 1'b1;
               state_in     = S_FETCH;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         window_size_ff <= 7'd1;
         fill_ff        <= '0;
         oldest_ff      <= '0;
         retire_ff      <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         oldest_ff    <= oldest_in;
         retire_ff    <= retire_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            window_size_ff <= csr_wdata;
         end
      end
      if (req_accept) begin
         sample_ff <= req_tdata;
      end
      if (state_ff == S_EVAL) begin
         lo_ff <= lo_value;
         hi_ff <= hi_value;
      end
      rsp_data_ff <= rsp_data_in;
   end

   `SWM_ASSERT_NOW(a_fill_bound, 1'b1, fill_ff <= CNT_W'(swm_pkg::WINDOW_MAX))
   `SWM_ASSERT_NOW(a_result_full, rsp_load, fill_ff == win_k)
   `SWM_ASSERT_NEXT(a_busy_after_accept, req_accept, state_ff == S_FETCH)
   `SWM_ASSERT_NEXT(a_retire_leaves_gap, (state_ff == S_TRIM) && retire_ff, fill_ff < win_k)

endmodule

FILE: sim/sliding_window_median_core_tb.sv
// Self-checking testbench for the sliding window median core.
module sliding_window_median_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SETTLE_CYCLES = 160;
   localparam int RANDOM_ITEMS  = 1450;
   localparam longint RUN_LIMIT_NS = 64'd10_000_000;

   // Tracks the window contents and the medians still owed by the core.
   class median_tracker;
      logic signed [swm_pkg::DATA_W-1:0] arrival_ring [swm_pkg::WINDOW_MAX];
      logic signed [swm_pkg::DATA_W-1:0] sorted_vals [swm_pkg::WINDOW_MAX];
      int held;
      int head;
      logic [6:0] window_reg;
      logic signed [swm_pkg::OUT_W-1:0] pending_medians[$];
      int mismatches;

      function new();
         held = 0;
         head = 0;
         window_reg = 7'd1;
         mismatches = 0;
      endfunction

      function void set_window(logic [6:0] value);
         window_reg = value;
      endfunction

      function int window_len();
         if (window_reg == 0) return 1;
         if (window_reg > swm_pkg::WINDOW_MAX) return swm_pkg::WINDOW_MAX;
         return int'(window_reg);
      endfunction

      function void drop_oldest();
         int i;
         int j;
         logic signed [swm_pkg::DATA_W-1:0] v;
         if (held == 0) return;
         v = arrival_ring[head];
         i = 0;
         while (i < held && sorted_vals[i] != v) i++;
         for (j = i; j + 1 < held; j++) sorted_vals[j] = sorted_vals[j + 1];
         held--;
         head = (head + 1) % swm_pkg::WINDOW_MAX;
      endfunction

      function void note_sample(logic signed [swm_pkg::DATA_W-1:0] sample, logic restart);
         int k;
         int i;
         logic signed [swm_pkg::OUT_W-1:0] lo;
         logic signed [swm_pkg::OUT_W-1:0] hi;
         logic signed [swm_pkg::OUT_W-1:0] sum;
         k = window_len();
         if (restart) begin
            held = 0;
            head = 0;
         end
         while (held >= k) drop_oldest();
         arrival_ring[(head + held) % swm_pkg::WINDOW_MAX] = sample;
         i = held;
         while (i > 0 && sorted_vals[i - 1] > sample) begin
            sorted_vals[i] = sorted_vals[i - 1];
            i--;
         end
         sorted_vals[i] = sample;
         held++;
         if (held == k) begin
            // odd window: both indexes hit the middle entry
            lo = sorted_vals[(k - 1) / 2];
            hi = sorted_vals[k / 2];
            sum = lo + hi;
            pending_medians = {pending_medians, sum};
            drop_oldest();
         end
      endfunction

      function void check_median(logic [39:0] data);
         logic signed [swm_pkg::OUT_W-1:0] want;
         logic signed [swm_pkg::OUT_W-1:0] got;
         if (pending_medians.size() == 0) begin
            $error("median_x2: no result expected, actual %0d",
                   $signed(data[swm_pkg::OUT_W-1:0]));
            mismatches++;
            return;
         end
         want = pending_medians.pop_front();
         got = data[swm_pkg::OUT_W-1:0];
         if (got !== want) begin
            $error("median_x2 mismatch: expected %0d, actual %0d", want, got);
            mismatches++;
         end
         if (data[39:swm_pkg::OUT_W] !== '0) begin
            $error("pad mismatch: expected 0, actual %0h", data[39:swm_pkg::OUT_W]);
            mismatches++;
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;   // [31:0] sample
   logic [0:0]  req_tuser = '0;   // [0] restart
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;        // [32:0] median_x2, [39:33] zero
   logic        csr_we = 1'b0;
   logic [6:0]  csr_wdata = '0;

   median_tracker tracker = new();
   bit idle_on = 1'b0;
   int stall_left = 0;

   sliding_window_median_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic int pick_gap();
      int r;
      if (!idle_on) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(4, 40);
   endfunction

   function automatic logic [31:0] pick_sample();
      case ($urandom_range(0, 7))
         0: begin
            case ($urandom_range(0, 3))
               0: return 32'h7FFF_FFFF;
               1: return 32'h8000_0000;
               2: return 32'h0000_0000;
               default: return 32'hFFFF_FFFF;
            endcase
         end
         // narrow range so equal samples are common
         1, 2: return 32'($urandom_range(0, 7)) - 32'd4;
         default: return $urandom;
      endcase
   endfunction

   // Result side: stall at random, check every accepted beat.
   always @(negedge clock) begin
      if (stall_left == 0) stall_left = pick_gap();
      if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left--;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) tracker.check_median(rsp_tdata);
   end

   task automatic send_sample(input logic [31:0] sample, input logic restart);
      int gap;
      gap = pick_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= sample;
      req_tuser <= restart;
      do @(posedge clock); while (!req_tready);
      tracker.note_sample(sample, restart);
   endtask

   // Hold off the sender until every owed median has come back.
   task automatic drain_medians();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (tracker.pending_medians.size() != 0) @(negedge clock);
   endtask

   task automatic write_window(input logic [6:0] value);
      drain_medians();
      // an item that fills no window may still be in flight
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_we <= 1'b1;
      csr_wdata <= value;
      tracker.set_window(value);
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   initial begin
      int sent;
      int phase;
      int len;
      int n;
      logic [6:0] w;

      repeat (4) @(negedge clock);
      reset <= 1'b0;

      // window of one from reset: extremes pass straight through
      send_sample(32'h7FFF_FFFF, 1'b0);
      send_sample(32'h8000_0000, 1'b0);
      send_sample(32'h0000_0000, 1'b0);
      send_sample(32'hFFFF_FFFF, 1'b0);

      write_window(7'd2);
      send_sample(32'h7FFF_FFFF, 1'b0);
      send_sample(32'h7FFF_FFFF, 1'b0);
      send_sample(32'h8000_0000, 1'b0);
      send_sample(32'h8000_0000, 1'b0);

      // equal samples, then a restart in the middle of a window
      write_window(7'd3);
      send_sample(32'd5, 1'b0);
      send_sample(32'd5, 1'b0);
      send_sample(32'd5, 1'b0);
      send_sample(32'd9, 1'b1);
      send_sample(32'd7, 1'b0);
      send_sample(32'd3, 1'b0);

      // zero behaves as a window of one
      write_window(7'd0);
      send_sample(32'hFFFF_FFFE, 1'b0);
      send_sample(32'd11, 1'b0);

      // shrink the window while samples are held
      write_window(7'd5);
      send_sample(32'd40, 1'b1);
      send_sample(32'd10, 1'b0);
      send_sample(32'd30, 1'b0);
      send_sample(32'd20, 1'b0);
      write_window(7'd2);
      send_sample(32'hFFFF_FFF0, 1'b0);

      sent = 0;
      phase = 0;
      while (sent < RANDOM_ITEMS) begin
         case ($urandom_range(0, 9))
            0: w = 7'd0;
            1: w = 7'd1;
            2: w = 7'd64;
            3: w = 7'($urandom_range(65, 127));
            4: w = 7'($urandom_range(17, 63));
            default: w = 7'($urandom_range(2, 16));
         endcase
         if (phase == 0 || $urandom_range(0, 4) != 0) write_window(w);
         idle_on = ($urandom_range(0, 3) != 0);
         len = (tracker.window_len() >= 32) ? $urandom_range(100, 160)
                                             : $urandom_range(20, 70);
         for (n = 0; n < len; n++) begin
            if (n == len / 2 && (phase == 0 || $urandom_range(0, 3) == 0)) drain_medians();
            send_sample(pick_sample(), $urandom_range(0, 99) == 0);
            sent++;
         end
         phase++;
      end

      drain_medians();
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (tracker.mismatches == 0 && tracker.pending_medians.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   initial begin
      #(RUN_LIMIT_NS);
      $display("FAILURE");
      $finish;
   end

endmodule

FILE: sliding_window_median_core.f
+incdir+design
design/swm_pkg.sv
design/swm_cell.sv
design/swm_chain.sv
design/sliding_window_median_core.sv
sim/sliding_window_median_core_tb.sv
